@@ src/julian_day_to_calendar_date_assert.svh @@
// assertion macros for the calendar converter
// expect clk and rst_n in the scope where they are used
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_ASSERT_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_ASSERT_SVH

// condition holds at every edge outside reset
`define JDC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("jdc: invariant violated");

// condition at one edge forces a result at the next edge
`define JDC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jdc: sequence violated");

`endif

@@ src/jdc_pkg.sv @@
package jdc_pkg;

    // field widths
    localparam int DC_W    = 23;
    localparam int DF_W    = 32;
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 22;

    // pipeline depth
    localparam int STAGES = 7;

    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
    } jdc_ctrl_t;

    // day fraction scaling
    localparam int FRAC_BITS  = 32;
    localparam int FRAC_USED  = (FRAC_BITS < DF_W) ? FRAC_BITS : DF_W;
    localparam int FRAC_SHIFT = FRAC_BITS - 16;
    localparam logic [DF_W-1:0] FRAC_MASK =
        DF_W'((64'd1 << FRAC_USED) - 64'd1);
    localparam int SEC_PER_DAY = 86400;
    localparam int SPD_W       = 17;
    localparam int PROD_W      = DF_W + SPD_W;
    localparam int TICK_W      = 33;

    // hour split: ticks per hour = 225 * 2^20
    localparam int H_DIV     = 225;
    localparam int H_IN_LSB  = 20;
    localparam int H_IN_W    = TICK_W - H_IN_LSB;
    localparam int H_SHIFT   = 21;
    localparam int H_RECIP_W = 14;
    localparam logic [63:0] H_RECIP =
        ((64'd1 << H_SHIFT) + 64'(H_DIV) - 64'd1) / 64'(H_DIV);
    localparam logic [63:0] TICKS_PER_HOUR = 64'(H_DIV) << H_IN_LSB;

    // minute split: ticks per minute = 15 * 2^18
    localparam int REM_W       = 28;
    localparam int MN_DIV      = 15;
    localparam int MN_IN_LSB   = 18;
    localparam int MN_IN_W     = REM_W - MN_IN_LSB;
    localparam int MN_SHIFT    = 14;
    localparam int MN_RECIP_W  = 11;
    localparam logic [63:0] MN_RECIP =
        ((64'd1 << MN_SHIFT) + 64'(MN_DIV) - 64'd1) / 64'(MN_DIV);
    localparam logic [63:0] TICKS_PER_MIN = 64'(MN_DIV) << MN_IN_LSB;

    // gregorian correction
    localparam logic [DC_W-1:0] GREG_SWITCH = DC_W'(2299160);
    localparam int XA_W      = 25;
    localparam int A_OFS     = 7468865;
    localparam int A_DIV     = 146097;
    localparam int A_SHIFT   = 43;
    localparam int A_RECIP_W = 26;
    localparam int A_W       = 8;
    localparam logic [63:0] A_RECIP =
        ((64'd1 << A_SHIFT) + 64'(A_DIV) - 64'd1) / 64'(A_DIV);

    // year of the julian period
    localparam int B_W       = 24;
    localparam int C_OFS     = 1524;
    localparam int XD_W      = 28;
    localparam int D_OFS     = 2442;
    localparam int D_DIV     = 7305;
    localparam int D_SHIFT   = 41;
    localparam int D_RECIP_W = 29;
    localparam int D_W       = 15;
    localparam logic [63:0] D_RECIP =
        ((64'd1 << D_SHIFT) + 64'(D_DIV) - 64'd1) / 64'(D_DIV);

    // day of year part, e = 1461 d / 4
    localparam int E_MUL    = 1461;
    localparam int E_PROD_W = 26;

    // month index, g = 10000 m / 306001 with m below 512
    localparam int M_W       = 9;
    localparam int G_DIV     = 306001;
    localparam int G_SHIFT   = 42;
    localparam int G_RECIP_W = 38;
    localparam int G_W       = 4;
    localparam logic [63:0] G_RECIP = 64'd10000 *
        (((64'd1 << G_SHIFT) + 64'(G_DIV) - 64'd1) / 64'(G_DIV));

    localparam int G_MONTH_WRAP  = 13;
    localparam int MONTH_FEB     = 2;
    localparam int YEAR_OFS_LATE = 4716;
    localparam int YEAR_OFS_EARLY = 4715;

endpackage

@@ src/jdc_if.sv @@
interface jdc_in_if import jdc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [DC_W-1:0] day_count;
    logic [DF_W-1:0] day_fraction;

    modport source (output valid, output day_count, output day_fraction, input ready);
    modport sink   (input valid, input day_count, input day_fraction, output ready);
endinterface

interface jdc_out_if import jdc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic [SEC_W-1:0]         second_fixed;

    modport source (output valid, output year, output month, output day, output hour,
                    output minute, output second_fixed, input ready);
    modport sink   (input valid, input year, input month, input day, input hour,
                    input minute, input second_fixed, output ready);
endinterface

@@ src/julian_day_to_calendar_date.sv @@
// Julian day to calendar date converter. Each request carries the whole day
// number floor(JD + 0.5) and the fraction of the day since midnight; the
// result gives the year (astronomical, signed), month, day, hour, minute and
// seconds in units of 2^-16 s, all truncated. Day numbers above 2299160 use
// the Gregorian calendar, lower ones the Julian calendar. The block is a
// seven-stage pipeline with a valid bit per stage: it takes one request per
// cycle while the result side is not stalled, and each result moves through
// stage registers 0 to 6, the last of which drives the outputs.
// The stage count is set by the date path, whose three constant divisions
// (by 146097, 7305 and 306001) are each a reciprocal multiply in a stage of
// its own. When the result side stalls, bubbles in the pipe still fill, so
// requests keep being taken until every stage holds an item.
`include "julian_day_to_calendar_date_assert.svh"

module julian_day_to_calendar_date import jdc_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    jdc_in_if.sink     jd,
    jdc_out_if.source  cal
);

    // per-stage load enables and valid bits shared by both data paths
    jdc_ctrl_t ctrl;

    jdc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (jd.valid),
        .in_ready  (jd.ready),
        .out_ready (cal.ready),
        .ctrl      (ctrl)
    );

    // date path: gregorian correction, year count, day-in-year, month split
    jdc_date_pipe u_date (
        .clk       (clk),
        .ctrl      (ctrl),
        .day_count (jd.day_count),
        .year      (cal.year),
        .month     (cal.month),
        .day       (cal.day)
    );

    // time path: scale fraction to ticks, then peel off hours and minutes
    jdc_time_pipe u_time (
        .clk          (clk),
        .ctrl         (ctrl),
        .day_fraction (jd.day_fraction),
        .hour         (cal.hour),
        .minute       (cal.minute),
        .second_fixed (cal.second_fixed)
    );

    // the last stage register is the output register
    assign cal.valid = ctrl.valid[STAGES-1];

    // results leaving the pipe are well formed calendar values
    `JDC_ASSERT_ALWAYS(a_month_range, !cal.valid || (cal.month >= 4'd1 && cal.month <= 4'd12))
    `JDC_ASSERT_ALWAYS(a_day_nonzero, !cal.valid || (cal.day != 5'd0))
    `JDC_ASSERT_ALWAYS(a_time_range, !cal.valid || (cal.hour <= 5'd23 && cal.minute <= 6'd59))
    // an accepted request lands in the first stage
    `JDC_ASSERT_NEXT(a_accept_lands, jd.valid && jd.ready, ctrl.valid[0])

endmodule

@@ src/jdc_pipe_ctrl.sv @@
module jdc_pipe_ctrl import jdc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    output jdc_ctrl_t ctrl
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;

    // a stage loads when empty or when its contents move on
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = load[0];
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule

@@ src/jdc_date_pipe.sv @@
module jdc_date_pipe import jdc_pkg::*; (
    input  logic                     clk,
    input  jdc_ctrl_t                ctrl,
    input  logic [DC_W-1:0]          day_count,
    output logic signed [YEAR_W-1:0] year,
    output logic [MONTH_W-1:0]       month,
    output logic [DAY_W-1:0]         day
);

    // floor(30.6001 g)
    function automatic logic [M_W-1:0] day_offset(input logic [G_W-1:0] g);
        logic [M_W-1:0] r;
        case (g)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd397;
            4'd14:   r = 9'd428;
            4'd15:   r = 9'd459;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    logic [DC_W-1:0]               i0_reg, i1_reg;
    logic                          greg0_reg, greg0_next, greg1_reg;
    logic [XA_W-1:0]               xa0_reg, xa0_next;
    logic [XA_W+A_RECIP_W-1:0]     a_prod;
    logic [A_W-1:0]                a1_reg, a1_next;
    logic [B_W-1:0]                b_sum;
    logic [B_W-1:0]                c2_reg, c2_next, c3_reg;
    logic [XD_W-1:0]               xd2_reg, xd2_next;
    logic [XD_W+D_RECIP_W-1:0]     d_prod;
    logic [D_W-1:0]                d3_reg, d3_next, d4_reg, d5_reg;
    logic [E_PROD_W-1:0]           e_prod;
    logic [B_W-1:0]                e_val;
    logic [M_W-1:0]                m4_reg, m4_next, m5_reg;
    logic [M_W+G_RECIP_W-1:0]      g_prod;
    logic [G_W-1:0]                g5_reg, g5_next;
    logic [DAY_W-1:0]              day_reg, day_next;
    logic [MONTH_W-1:0]            month_reg, month_next;
    logic [YEAR_W-1:0]             year_reg, year_next;

    // stage 0: switch test and correction numerator
    assign greg0_next = day_count > GREG_SWITCH;
    assign xa0_next   = {day_count, 2'b00} - XA_W'(A_OFS);

    // stage 1: century count a
    assign a_prod  = (XA_W+A_RECIP_W)'(xa0_reg) * (XA_W+A_RECIP_W)'(A_RECIP[A_RECIP_W-1:0]);
    assign a1_next = a_prod[A_SHIFT +: A_W];

    // stage 2: corrected day number and numerator for d
    assign b_sum    = greg1_reg ? (B_W'(i1_reg) + B_W'(1) + B_W'(a1_reg) - B_W'(a1_reg >> 2))
                                : B_W'(i1_reg);
    assign c2_next  = b_sum + B_W'(C_OFS);
    assign xd2_next = (XD_W'(c2_next) << 4) + (XD_W'(c2_next) << 2) - XD_W'(D_OFS);

    // stage 3: d
    assign d_prod  = (XD_W+D_RECIP_W)'(xd2_reg) * (XD_W+D_RECIP_W)'(D_RECIP[D_RECIP_W-1:0]);
    assign d3_next = d_prod[D_SHIFT +: D_W];

    // stage 4: days left in the year, always below 512
    assign e_prod  = E_PROD_W'(d3_reg) * E_PROD_W'(E_MUL);
    assign e_val   = e_prod[2 +: B_W];
    assign m4_next = M_W'(c3_reg - e_val);

    // stage 5: month index g
    assign g_prod  = (M_W+G_RECIP_W)'(m4_reg) * (M_W+G_RECIP_W)'(G_RECIP[G_RECIP_W-1:0]);
    assign g5_next = g_prod[G_SHIFT +: G_W];

    // stage 6: day, month, year
    always_comb
    begin
        day_next = DAY_W'(m5_reg - day_offset(g5_reg));
        if (g5_reg <= G_W'(G_MONTH_WRAP))
        begin
            month_next = MONTH_W'(g5_reg - G_W'(1));
        end
        else
        begin
            month_next = MONTH_W'(g5_reg - G_W'(G_MONTH_WRAP));
        end
        if (month_next > MONTH_W'(MONTH_FEB))
        begin
            year_next = YEAR_W'(d5_reg) - YEAR_W'(YEAR_OFS_LATE);
        end
        else
        begin
            year_next = YEAR_W'(d5_reg) - YEAR_W'(YEAR_OFS_EARLY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            i0_reg    <= day_count;
            greg0_reg <= greg0_next;
            xa0_reg   <= xa0_next;
        end
        if (ctrl.load[1])
        begin
            i1_reg    <= i0_reg;
            greg1_reg <= greg0_reg;
            a1_reg    <= a1_next;
        end
        if (ctrl.load[2])
        begin
            c2_reg  <= c2_next;
            xd2_reg <= xd2_next;
        end
        if (ctrl.load[3])
        begin
            c3_reg <= c2_reg;
            d3_reg <= d3_next;
        end
        if (ctrl.load[4])
        begin
            d4_reg <= d3_reg;
            m4_reg <= m4_next;
        end
        if (ctrl.load[5])
        begin
            d5_reg <= d4_reg;
            m5_reg <= m4_reg;
            g5_reg <= g5_next;
        end
        if (ctrl.load[6])
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    assign year  = $signed(year_reg);
    assign month = month_reg;
    assign day   = day_reg;

endmodule

@@ src/jdc_time_pipe.sv @@
module jdc_time_pipe import jdc_pkg::*; (
    input  logic              clk,
    input  jdc_ctrl_t         ctrl,
    input  logic [DF_W-1:0]   day_fraction,
    output logic [HOUR_W-1:0] hour,
    output logic [MIN_W-1:0]  minute,
    output logic [SEC_W-1:0]  second_fixed
);

    logic [PROD_W-1:0]             tick_prod, tick_shift;
    logic [TICK_W-1:0]             t0_reg, t0_next, t1_reg;
    logic [H_IN_W+H_RECIP_W-1:0]   h_prod;
    logic [HOUR_W-1:0]             hour1_reg, hour1_next;
    logic [HOUR_W-1:0]             hour2_reg, hour3_reg, hour4_reg, hour5_reg, hour6_reg;
    logic [REM_W-1:0]              rem2_reg, rem2_next, rem3_reg;
    logic [MN_IN_W+MN_RECIP_W-1:0] mn_prod;
    logic [MIN_W-1:0]              min3_reg, min3_next, min4_reg, min5_reg, min6_reg;
    logic [SEC_W-1:0]              sec4_reg, sec4_next, sec5_reg, sec6_reg;

    // stage 0: ticks of 2^-16 s since midnight
    assign tick_prod  = PROD_W'(day_fraction & FRAC_MASK) * PROD_W'(SEC_PER_DAY);
    assign tick_shift = tick_prod >> FRAC_SHIFT;
    assign t0_next    = tick_shift[TICK_W-1:0];

    // stage 1: hour
    assign h_prod     = (H_IN_W+H_RECIP_W)'(t0_reg[TICK_W-1:H_IN_LSB])
                        * (H_IN_W+H_RECIP_W)'(H_RECIP[H_RECIP_W-1:0]);
    assign hour1_next = h_prod[H_SHIFT +: HOUR_W];

    // stage 2: remainder within the hour
    assign rem2_next = REM_W'(t1_reg - TICK_W'(hour1_reg) * TICK_W'(TICKS_PER_HOUR));

    // stage 3: minute
    assign mn_prod   = (MN_IN_W+MN_RECIP_W)'(rem2_reg[REM_W-1:MN_IN_LSB])
                       * (MN_IN_W+MN_RECIP_W)'(MN_RECIP[MN_RECIP_W-1:0]);
    assign min3_next = mn_prod[MN_SHIFT +: MIN_W];

    // stage 4: remainder within the minute
    assign sec4_next = SEC_W'(rem3_reg - REM_W'(min3_reg) * REM_W'(TICKS_PER_MIN));

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            t0_reg <= t0_next;
        end
        if (ctrl.load[1])
        begin
            t1_reg    <= t0_reg;
            hour1_reg <= hour1_next;
        end
        if (ctrl.load[2])
        begin
            rem2_reg  <= rem2_next;
            hour2_reg <= hour1_reg;
        end
        if (ctrl.load[3])
        begin
            rem3_reg  <= rem2_reg;
            min3_reg  <= min3_next;
            hour3_reg <= hour2_reg;
        end
        if (ctrl.load[4])
        begin
            sec4_reg  <= sec4_next;
            min4_reg  <= min3_reg;
            hour4_reg <= hour3_reg;
        end
        if (ctrl.load[5])
        begin
            sec5_reg  <= sec4_reg;
            min5_reg  <= min4_reg;
            hour5_reg <= hour4_reg;
        end
        if (ctrl.load[6])
        begin
            sec6_reg  <= sec5_reg;
            min6_reg  <= min5_reg;
            hour6_reg <= hour5_reg;
        end
    end

    assign hour         = hour6_reg;
    assign minute       = min6_reg;
    assign second_fixed = sec6_reg;

endmodule
